FILE: hw/rtl/mts_pkg.sv
`default_nettype none
package mts_pkg;

    // Note table sizing: slots are 8 bits wide and melodies hold at most 256 notes
    localparam int MELODY_DEPTH = 256;
    localparam int TABLE_DEPTH  = (MELODY_DEPTH < 256) ? MELODY_DEPTH : 256;
    localparam int TABLE_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Entry layout: duration in the upper half, frequency in the lower half
    localparam int ENTRY_W = 32;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Configuration reset values
    localparam logic [27:0] TIMER_CLOCK_RESET = 28'd80000000;
    localparam logic [15:0] PRESCALER_RESET   = 16'd0;
    localparam logic [6:0]  DUTY_RESET        = 7'd30;
    localparam logic [7:0]  GAP_RESET         = 8'd20;

    // Sequencer limits
    localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
    localparam logic [6:0]  DUTY_MAX    = 7'd100;
    localparam logic [8:0]  LEN_MAX     = 9'(TABLE_DEPTH);

    // Shared divider geometry: 28-bit dividend, 17-bit divisor
    localparam int DIV_NW  = 28;
    localparam int DIV_DW  = 17;
    localparam int DIV_CW  = $clog2(DIV_NW);

    // Valid timer quotient range (reload 2..65535)
    localparam logic [27:0] TONE_Q_MIN = 28'd3;
    localparam logic [27:0] TONE_Q_MAX = 28'd65536;

    // Division by 100 through a reciprocal: exact for products below 2^23
    localparam logic [23:0] DIV100_MULT  = 24'd10737419;
    localparam int          DIV100_SHIFT = 30;
    localparam logic [16:0] CMP_MAX      = 17'h0FFFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_TIMER_CLOCK = 2'd0,
        REG_PRESCALER   = 2'd1,
        REG_DUTY        = 2'd2,
        REG_GAP         = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EVAL,
        SEQ_TONE,
        SEQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        TC_IDLE,
        TC_DIV_CLK,
        TC_DIV_FREQ,
        TC_SCALE,
        TC_RECIP,
        TC_DONE
    } tc_state_t;

    // Timer settings produced by the tone calculator
    typedef struct packed {
        logic        ok;
        logic [15:0] period;
        logic [15:0] high;
    } tone_result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/melody_tone_sequencer_core.sv
`default_nettype none
// Melody tone sequencer: note entries (frequency, duration) are written into a
// 256-entry table with op 0, op 1 starts playback of the first melody_len notes
// (zero stops), and op 2 is the 1 ms tick that advances notes and gaps. Every
// input transfer yields exactly one result transfer carrying the timer settings
// and playback status after that item. Table writes, stops, unknown ops and idle
// ticks go straight to publishing their result, and other ticks evaluate the
// current note first. A tone load for a rest or a zero timer clock ends in the
// tone calculator without dividing; other tone loads run the two 28-step
// divisions (clock by prescaler, then by frequency) in the shared radix-2
// divider and skip the duty scaling when the reload falls out of range. One item
// is worked on at a time; the next item is accepted the cycle after a result is
// published, and a finished result may wait in the output register meanwhile.
// Configuration registers sit at byte addresses 0 (timer clock), 4 (prescaler),
// 8 (duty) and 12 (gap).
module melody_tone_sequencer_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mts_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [mts_pkg::PDATA_W-1:0]  pwdata,
    output logic      [mts_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,

    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   op,
    input  wire logic [7:0]                   note_slot,
    input  wire logic [15:0]                  note_freq_hz,
    input  wire logic [15:0]                  note_duration_ms,
    input  wire logic [8:0]                   melody_len,

    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              tone_on,
    output logic      [15:0]                  reload_value,
    output logic      [15:0]                  compare_value,
    output logic                              playing,
    output logic                              in_gap,
    output logic      [8:0]                   current_note
);

    // Configuration registers
    logic [27:0] timer_clock_reg;
    logic [15:0] prescaler_reg;
    logic [6:0]  duty_reg;
    logic [7:0]  gap_reg;

    // Sequencer state
    mts_pkg::seq_state_t state_reg, state_next;
    mts_pkg::op_t        op_reg, op_next;
    logic [8:0]          active_len_reg, active_len_next;
    logic [8:0]          note_pos_reg, note_pos_next;
    logic [16:0]         elapsed_reg, elapsed_next;
    logic                play_reg, play_next;
    logic                gapping_reg, gapping_next;
    logic                tone_reg, tone_next;
    logic [15:0]         period_reg, period_next;
    logic [15:0]         high_reg, high_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic        tone_on_reg, tone_on_next;
    logic [15:0] reload_reg, reload_next;
    logic [15:0] compare_reg, compare_next;
    logic        playing_reg, playing_next;
    logic        in_gap_reg, in_gap_next;
    logic [8:0]  cur_note_reg, cur_note_next;

    // Note table port
    logic                         ram_we;
    logic [mts_pkg::TABLE_AW-1:0] ram_raddr;
    logic [mts_pkg::ENTRY_W-1:0]  ram_rdata;

    // Tone calculator handshake
    logic                  tone_start;
    logic                  tone_done;
    mts_pkg::tone_result_t tone_result;

    logic       in_accept;
    logic [8:0] len_sat;
    logic [8:0] pos_inc;
    logic       cfg_write;

    mts_ram #(
        .DEPTH (mts_pkg::TABLE_DEPTH),
        .WIDTH (mts_pkg::ENTRY_W)
    ) u_note_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (note_slot[mts_pkg::TABLE_AW-1:0]),
        .wdata ({note_duration_ms, note_freq_hz}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mts_tone_calc u_tone_calc (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (tone_start),
        .freq           (ram_rdata[15:0]),
        .timer_clock_hz (timer_clock_reg),
        .prescaler      (prescaler_reg),
        .duty_percent   (duty_reg),
        .done           (tone_done),
        .result         (tone_result)
    );

    // Configuration port: writes complete in the access phase, no wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (mts_pkg::reg_idx_t'(paddr[3:2]))
            mts_pkg::REG_TIMER_CLOCK: prdata = {4'd0, timer_clock_reg};
            mts_pkg::REG_PRESCALER:   prdata = {16'd0, prescaler_reg};
            mts_pkg::REG_DUTY:        prdata = {25'd0, duty_reg};
            mts_pkg::REG_GAP:         prdata = {24'd0, gap_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= mts_pkg::TIMER_CLOCK_RESET;
            prescaler_reg   <= mts_pkg::PRESCALER_RESET;
            duty_reg        <= mts_pkg::DUTY_RESET;
            gap_reg         <= mts_pkg::GAP_RESET;
        end
        else if (cfg_write)
        begin
            case (mts_pkg::reg_idx_t'(paddr[3:2]))
                mts_pkg::REG_TIMER_CLOCK: timer_clock_reg <= pwdata[27:0];
                mts_pkg::REG_PRESCALER:   prescaler_reg   <= pwdata[15:0];
                mts_pkg::REG_DUTY:        duty_reg        <= pwdata[6:0];
                mts_pkg::REG_GAP:         gap_reg         <= pwdata[7:0];
                default:                  ;
            endcase
        end
    end

    // Input side takes one item at a time
    assign in_stall  = (state_reg != mts_pkg::SEQ_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign len_sat   = (melody_len > mts_pkg::LEN_MAX) ? mts_pkg::LEN_MAX : melody_len;
    assign pos_inc   = note_pos_reg + 9'd1;

    // Sequencer: accept, read the note entry, evaluate, load tone, publish
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        active_len_next = active_len_reg;
        note_pos_next   = note_pos_reg;
        elapsed_next    = elapsed_reg;
        play_next       = play_reg;
        gapping_next    = gapping_reg;
        tone_next       = tone_reg;
        period_next     = period_reg;
        high_next       = high_reg;
        ram_we          = 1'b0;
        ram_raddr       = note_pos_reg[mts_pkg::TABLE_AW-1:0];
        tone_start      = 1'b0;

        out_valid_next  = out_valid_reg && out_stall;
        tone_on_next    = tone_on_reg;
        reload_next     = reload_reg;
        compare_next    = compare_reg;
        playing_next    = playing_reg;
        in_gap_next     = in_gap_reg;
        cur_note_next   = cur_note_reg;

        case (state_reg)
            mts_pkg::SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    op_next    = mts_pkg::op_t'(op);
                    state_next = mts_pkg::SEQ_DONE;
                    case (mts_pkg::op_t'(op))
                        mts_pkg::OP_WRITE:
                        begin
                            ram_we = ({1'b0, note_slot} < mts_pkg::LEN_MAX);
                        end
                        mts_pkg::OP_START:
                        begin
                            note_pos_next = '0;
                            gapping_next  = 1'b0;
                            elapsed_next  = '0;
                            ram_raddr     = '0;
                            if (len_sat == 9'd0)
                            begin
                                active_len_next = '0;
                                play_next       = 1'b0;
                                tone_next       = 1'b0;
                                high_next       = '0;
                            end
                            else
                            begin
                                active_len_next = len_sat;
                                play_next       = 1'b1;
                                state_next      = mts_pkg::SEQ_EVAL;
                            end
                        end
                        mts_pkg::OP_TICK:
                        begin
                            if (play_reg)
                            begin
                                if (elapsed_reg < mts_pkg::ELAPSED_MAX)
                                begin
                                    elapsed_next = elapsed_reg + 17'd1;
                                end
                                state_next = mts_pkg::SEQ_EVAL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mts_pkg::SEQ_EVAL:
            begin
                state_next = mts_pkg::SEQ_DONE;
                if (op_reg == mts_pkg::OP_START)
                begin
                    tone_start = 1'b1;
                    state_next = mts_pkg::SEQ_TONE;
                end
                else if (gapping_reg)
                begin
                    // Gap over: load the tone of the pending note
                    if (elapsed_reg >= {9'd0, gap_reg})
                    begin
                        gapping_next = 1'b0;
                        elapsed_next = '0;
                        tone_start   = 1'b1;
                        state_next   = mts_pkg::SEQ_TONE;
                    end
                end
                else if (elapsed_reg >= {1'b0, ram_rdata[31:16]})
                begin
                    // Note over: go to gap, or finish after the last note
                    note_pos_next = pos_inc;
                    elapsed_next  = '0;
                    if (pos_inc < active_len_reg)
                    begin
                        gapping_next = 1'b1;
                    end
                    else
                    begin
                        play_next    = 1'b0;
                        gapping_next = 1'b0;
                    end
                    tone_next = 1'b0;
                    high_next = '0;
                end
            end
            mts_pkg::SEQ_TONE:
            begin
                if (tone_done)
                begin
                    if (tone_result.ok)
                    begin
                        tone_next   = 1'b1;
                        period_next = tone_result.period;
                        high_next   = tone_result.high;
                    end
                    else
                    begin
                        tone_next = 1'b0;
                        high_next = '0;
                    end
                    state_next = mts_pkg::SEQ_DONE;
                end
            end
            mts_pkg::SEQ_DONE:
            begin
                // Publish once the output register is free
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    tone_on_next   = tone_reg;
                    reload_next    = period_reg;
                    compare_next   = high_reg;
                    playing_next   = play_reg;
                    in_gap_next    = gapping_reg;
                    cur_note_next  = note_pos_reg;
                    state_next     = mts_pkg::SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mts_pkg::SEQ_IDLE;
            active_len_reg <= '0;
            note_pos_reg   <= '0;
            elapsed_reg    <= '0;
            play_reg       <= 1'b0;
            gapping_reg    <= 1'b0;
            tone_reg       <= 1'b0;
            period_reg     <= '0;
            high_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_len_reg <= active_len_next;
            note_pos_reg   <= note_pos_next;
            elapsed_reg    <= elapsed_next;
            play_reg       <= play_next;
            gapping_reg    <= gapping_next;
            tone_reg       <= tone_next;
            period_reg     <= period_next;
            high_reg       <= high_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        tone_on_reg  <= tone_on_next;
        reload_reg   <= reload_next;
        compare_reg  <= compare_next;
        playing_reg  <= playing_next;
        in_gap_reg   <= in_gap_next;
        cur_note_reg <= cur_note_next;
    end

    assign out_valid     = out_valid_reg;
    assign tone_on       = tone_on_reg;
    assign reload_value  = reload_reg;
    assign compare_value = compare_reg;
    assign playing       = playing_reg;
    assign in_gap        = in_gap_reg;
    assign current_note  = cur_note_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/mts_ram.sv
`default_nettype none
module mts_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: hw/rtl/mts_divider.sv
`default_nettype none
module mts_divider (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mts_pkg::DIV_NW-1:0] dividend,
    input  wire logic [mts_pkg::DIV_DW-1:0] divisor,
    output logic                            done,
    output logic      [mts_pkg::DIV_NW-1:0] quotient
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [mts_pkg::DIV_CW-1:0] count_reg, count_next;
    logic [mts_pkg::DIV_DW-1:0] rem_reg, rem_next;
    logic [mts_pkg::DIV_NW-1:0] quot_reg, quot_next;
    logic [mts_pkg::DIV_DW-1:0] divisor_reg, divisor_next;
    logic [mts_pkg::DIV_DW:0]   rem_shift;
    logic [mts_pkg::DIV_DW+1:0] diff;

    // One restoring step per cycle, dividend bits shift out as quotient bits shift in
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        rem_shift    = {rem_reg, quot_reg[mts_pkg::DIV_NW-1]};
        diff         = {1'b0, rem_shift} - {2'b00, divisor_reg};

        if (start)
        begin
            busy_next    = 1'b1;
            count_next   = mts_pkg::DIV_CW'(mts_pkg::DIV_NW - 1);
            rem_next     = '0;
            quot_next    = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[mts_pkg::DIV_DW+1])
            begin
                rem_next  = diff[mts_pkg::DIV_DW-1:0];
                quot_next = {quot_reg[mts_pkg::DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[mts_pkg::DIV_DW-1:0];
                quot_next = {quot_reg[mts_pkg::DIV_NW-2:0], 1'b0};
            end
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - mts_pkg::DIV_CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/mts_tone_calc.sv
`default_nettype none
module mts_tone_calc (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [15:0]           freq,
    input  wire logic [27:0]           timer_clock_hz,
    input  wire logic [15:0]           prescaler,
    input  wire logic [6:0]            duty_percent,
    output logic                       done,
    output mts_pkg::tone_result_t      result
);

    mts_pkg::tc_state_t    state_reg, state_next;
    mts_pkg::tone_result_t result_reg, result_next;
    logic [15:0]           freq_reg, freq_next;
    logic [27:0]           quot_reg, quot_next;
    logic [23:0]           prod_reg, prod_next;

    logic                       div_start;
    logic [mts_pkg::DIV_NW-1:0] div_dividend;
    logic [mts_pkg::DIV_DW-1:0] div_divisor;
    logic                       div_done;
    logic [mts_pkg::DIV_NW-1:0] div_quot;

    logic [6:0]  duty_sat;
    logic [47:0] recip;
    logic [16:0] cmp;
    logic [16:0] period_full;

    mts_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequence: clock / (prescaler + 1), then / freq, then scale by duty / 100
    always_comb
    begin
        state_next   = state_reg;
        result_next  = result_reg;
        freq_next    = freq_reg;
        quot_next    = quot_reg;
        prod_next    = prod_reg;
        div_start    = 1'b0;
        div_dividend = timer_clock_hz;
        div_divisor  = {1'b0, prescaler} + 17'd1;
        duty_sat     = (duty_percent > mts_pkg::DUTY_MAX) ? mts_pkg::DUTY_MAX : duty_percent;
        recip        = {24'd0, prod_reg} * {24'd0, mts_pkg::DIV100_MULT};
        cmp          = recip[mts_pkg::DIV100_SHIFT +: 17];
        period_full  = quot_reg[16:0] - 17'd1;

        case (state_reg)
            mts_pkg::TC_IDLE:
            begin
                if (start)
                begin
                    freq_next = freq;
                    if ((freq == 16'd0) || (timer_clock_hz == 28'd0))
                    begin
                        result_next.ok = 1'b0;
                        state_next     = mts_pkg::TC_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = mts_pkg::TC_DIV_CLK;
                    end
                end
            end
            mts_pkg::TC_DIV_CLK:
            begin
                div_dividend = div_quot;
                div_divisor  = {1'b0, freq_reg};
                if (div_done)
                begin
                    div_start  = 1'b1;
                    state_next = mts_pkg::TC_DIV_FREQ;
                end
            end
            mts_pkg::TC_DIV_FREQ:
            begin
                if (div_done)
                begin
                    quot_next = div_quot;
                    if ((div_quot < mts_pkg::TONE_Q_MIN) || (div_quot > mts_pkg::TONE_Q_MAX))
                    begin
                        result_next.ok = 1'b0;
                        state_next     = mts_pkg::TC_DONE;
                    end
                    else
                    begin
                        state_next = mts_pkg::TC_SCALE;
                    end
                end
            end
            mts_pkg::TC_SCALE:
            begin
                prod_next  = {7'd0, quot_reg[16:0]} * {17'd0, duty_sat};
                state_next = mts_pkg::TC_RECIP;
            end
            mts_pkg::TC_RECIP:
            begin
                result_next.ok     = 1'b1;
                result_next.period = period_full[15:0];
                result_next.high   = (cmp > mts_pkg::CMP_MAX) ? 16'hFFFF : cmp[15:0];
                state_next         = mts_pkg::TC_DONE;
            end
            mts_pkg::TC_DONE:
            begin
                state_next = mts_pkg::TC_IDLE;
            end
            default:
            begin
                state_next = mts_pkg::TC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::TC_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        freq_reg   <= freq_next;
        quot_reg   <= quot_next;
        prod_reg   <= prod_next;
    end

    assign done   = (state_reg == mts_pkg::TC_DONE);
    assign result = result_reg;

endmodule
`default_nettype wire
